/* design/shc_pkg.sv */
// ----------------------------------------------------------------------------
// shc_pkg
// Shared constants, stage payload types and helpers for the seasonal hour
// calculator pipeline.
// ----------------------------------------------------------------------------
package shc_pkg;

    localparam int MinuteW = 11;
    localparam int ScaledW = 15;
    localparam int QuotW   = 4;
    localparam int TotalW  = 7;

    localparam logic [MinuteW-1:0] MAX_MINUTE      = 11'd1439;
    localparam logic [11:0]        MINUTES_PER_DAY = 12'd1440;
    localparam logic [QuotW-1:0]   HOURS_FULL      = 4'd12;
    localparam logic [QuotW-1:0]   HOURS_LAST      = 4'd11;
    localparam logic [TotalW-1:0]  MINUTES_PER_HR  = 7'd60;
    // floor(x/12) == (x*2731) >> 15 for x below 1440
    localparam logic [11:0]        RECIP12         = 12'd2731;
    localparam int                 RecipShift      = 15;

    localparam logic [MinuteW-1:0] SUNRISE_RST = 11'd360;
    localparam logic [MinuteW-1:0] SUNSET_RST  = 11'd1080;

    typedef enum logic [1:0] {
        REG_SUNRISE = 2'd0,
        REG_SUNSET  = 2'd1
    } t_reg_idx;

    // after the prep stage
    typedef struct packed {
        logic               fault;
        logic               day;
        logic [MinuteW-1:0] len;
        logic [ScaledW-1:0] e12;
    } t_prep;

    // inside and after the divider
    typedef struct packed {
        logic               fault;
        logic               day;
        logic [MinuteW-1:0] len;
        logic [ScaledW-1:0] rem;
        logic [QuotW-1:0]   quot;
    } t_div;

    function automatic logic [MinuteW-1:0] clamp_minute(input logic [MinuteW-1:0] v);
        clamp_minute = (v > MAX_MINUTE) ? MAX_MINUTE : v;
    endfunction

endpackage

/* design/shc_prep.sv */
// ----------------------------------------------------------------------------
// shc_prep
// First pipeline stage: clamps inputs, picks day or night, and forms the
// period length and twelve times the elapsed minutes.
// ----------------------------------------------------------------------------
module shc_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [shc_pkg::MinuteW-1:0]  i_now,
    input  logic [shc_pkg::MinuteW-1:0]  i_sunrise,
    input  logic [shc_pkg::MinuteW-1:0]  i_sunset,
    output logic                         o_valid,
    input  logic                         i_stall,
    output shc_pkg::t_prep               o_data
);
    import shc_pkg::*;

    logic                r_vld;
    t_prep               r_data;
    t_prep               n_data;
    logic                ready;
    logic [MinuteW-1:0]  now_c;
    logic [MinuteW-1:0]  sr_c;
    logic [MinuteW-1:0]  ss_c;
    logic [MinuteW-1:0]  span;
    logic [11:0]         len_w;
    logic [11:0]         e_w;
    logic [ScaledW-1:0]  e_x;

    assign ready   = !r_vld || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_comb begin
        now_c = clamp_minute(i_now);
        sr_c  = clamp_minute(i_sunrise);
        ss_c  = clamp_minute(i_sunset);
        span  = ss_c - sr_c;
        n_data.fault = (ss_c <= sr_c);
        n_data.day   = (now_c >= sr_c) && (now_c <= ss_c);
        if (n_data.day) begin
            len_w = {1'b0, span};
            e_w   = {1'b0, now_c - sr_c};
        end else begin
            len_w = MINUTES_PER_DAY - {1'b0, span};
            // before sunrise the night started the previous evening
            if (now_c < sr_c) begin
                e_w = {1'b0, now_c} + MINUTES_PER_DAY - {1'b0, ss_c};
            end else begin
                e_w = {1'b0, now_c - ss_c};
            end
        end
        n_data.len = len_w[MinuteW-1:0];
        e_x        = {{(ScaledW-MinuteW){1'b0}}, e_w[MinuteW-1:0]};
        n_data.e12 = (e_x << 3) + (e_x << 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

/* design/shc_div.sv */
// ----------------------------------------------------------------------------
// shc_div
// Two-stage restoring divider: 12*elapsed by period length, two quotient
// bits per stage, leaving the remainder.
// ----------------------------------------------------------------------------
module shc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  shc_pkg::t_prep i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output shc_pkg::t_div  o_data
);
    import shc_pkg::*;

    logic               r_vld_a;
    logic               r_vld_b;
    t_div               r_a;
    t_div               r_b;
    t_div               n_a;
    t_div               n_b;
    logic               ready_a;
    logic               ready_b;
    logic [ScaledW-1:0] d3;
    logic [ScaledW-1:0] d2;
    logic [ScaledW-1:0] d1;
    logic [ScaledW-1:0] d0;
    logic [ScaledW-1:0] rp;

    assign ready_b = !r_vld_b || !i_stall;
    assign ready_a = !r_vld_a || ready_b;
    assign o_stall = !ready_a;
    assign o_valid = r_vld_b;
    assign o_data  = r_b;

    // quotient bits 3 and 2
    always_comb begin
        d3 = {1'b0, i_data.len, 3'b000};
        d2 = {2'b00, i_data.len, 2'b00};
        n_a.fault   = i_data.fault;
        n_a.day     = i_data.day;
        n_a.len     = i_data.len;
        n_a.quot    = '0;
        rp          = i_data.e12;
        n_a.quot[3] = (rp >= d3);
        if (n_a.quot[3]) begin
            rp = rp - d3;
        end
        n_a.quot[2] = (rp >= d2);
        if (n_a.quot[2]) begin
            rp = rp - d2;
        end
        n_a.rem = rp;
    end

    // quotient bits 1 and 0
    always_comb begin
        d1 = {3'b000, r_a.len, 1'b0};
        d0 = {4'b0000, r_a.len};
        n_b         = r_a;
        n_b.quot[1] = (r_a.rem >= d1);
        n_b.rem     = n_b.quot[1] ? (r_a.rem - d1) : r_a.rem;
        n_b.quot[0] = (n_b.rem >= d0);
        if (n_b.quot[0]) begin
            n_b.rem = n_b.rem - d0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_vld_a <= i_valid;
            end
            if (ready_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_a <= n_a;
        end
        if (ready_b && r_vld_a) begin
            r_b <= n_b;
        end
    end

endmodule

/* design/shc_split.sv */
// ----------------------------------------------------------------------------
// shc_split
// Turns quotient and remainder into the hour number and the time left,
// divides the time left by twelve and splits it into hours and minutes.
// ----------------------------------------------------------------------------
module shc_split (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  shc_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_is_day,
    output logic [3:0]    o_hour_number,
    output logic [1:0]    o_hours_to_next,
    output logic [5:0]    o_minutes_to_next,
    output logic          o_config_fault
);
    import shc_pkg::*;

    logic               r_vld_c;
    logic               r_vld_d;
    logic               r_fault_c;
    logic               r_day_c;
    logic [QuotW-1:0]   r_z_c;
    logic [TotalW-1:0]  r_total_c;
    logic               r_is_day;
    logic [3:0]         r_hour_number;
    logic [1:0]         r_hours_to_next;
    logic [5:0]         r_minutes_to_next;
    logic               r_config_fault;
    logic               ready_c;
    logic               ready_d;
    logic               sat;
    logic [QuotW-1:0]   n_z_c;
    logic [MinuteW-1:0] left12;
    logic [22:0]        prod;
    logic               hr_flag;
    logic [TotalW-1:0]  mins;

    assign ready_d = !r_vld_d || !i_stall;
    assign ready_c = !r_vld_c || ready_d;
    assign o_stall = !ready_c;
    assign o_valid = r_vld_d;

    assign o_is_day          = r_is_day;
    assign o_hour_number     = r_hour_number;
    assign o_hours_to_next   = r_hours_to_next;
    assign o_minutes_to_next = r_minutes_to_next;
    assign o_config_fault    = r_config_fault;

    // exactly at the period end the quotient is twelve: last hour, nothing left
    always_comb begin
        sat    = (i_data.quot == HOURS_FULL);
        n_z_c  = sat ? HOURS_LAST : i_data.quot;
        left12 = sat ? '0 : (i_data.len - i_data.rem[MinuteW-1:0]);
        prod   = 23'(left12) * 23'(RECIP12);
    end

    always_comb begin
        hr_flag = (r_total_c >= MINUTES_PER_HR);
        mins    = hr_flag ? (r_total_c - MINUTES_PER_HR) : r_total_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (ready_c) begin
                r_vld_c <= i_valid;
            end
            if (ready_d) begin
                r_vld_d <= r_vld_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && i_valid) begin
            r_fault_c <= i_data.fault;
            r_day_c   <= i_data.day;
            r_z_c     <= n_z_c;
            r_total_c <= prod[RecipShift+TotalW-1:RecipShift];
        end
        if (ready_d && r_vld_c) begin
            r_config_fault <= r_fault_c;
            if (r_fault_c) begin
                r_is_day          <= 1'b0;
                r_hour_number     <= '0;
                r_hours_to_next   <= '0;
                r_minutes_to_next <= '0;
            end else begin
                r_is_day          <= r_day_c;
                r_hour_number     <= r_z_c + 4'd1;
                r_hours_to_next   <= {1'b0, hr_flag};
                r_minutes_to_next <= mins[5:0];
            end
        end
    end

endmodule

/* design/seasonal_hour_calculator_top.sv */
// ----------------------------------------------------------------------------
// seasonal_hour_calculator_top
// Temporal hour calculator: twelve equal hours per day or night period.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_stall carries i_now_minute
//   output channel o_out_valid / i_out_stall carries is_day, hour number,
//   hours and minutes to the next temporal hour, and the fault flag
//   config channel i_cfg_valid / o_cfg_ready, index 0 sunrise, 1 sunset;
//   always ready, write only while no item is in flight
//   stages: five register stages lie between input transfer and o_out_valid
//   (prep, two divider stages, remainder scale, split)
//   throughput: one item per cycle, every stage taking one, when not stalled
//   reset: pipeline empties, sunrise 360 and sunset 1080
//   stall: a stalled result holds its output register; stages behind it
//   keep filling, and o_in_stall rises only once all five stages hold items
//   when sunset is not after sunrise, config_fault is set, other fields 0
// ----------------------------------------------------------------------------
module seasonal_hour_calculator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [shc_pkg::MinuteW-1:0] i_now_minute,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_is_day,
    output logic [3:0]                  o_hour_number,
    output logic [1:0]                  o_hours_to_next,
    output logic [5:0]                  o_minutes_to_next,
    output logic                        o_config_fault,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [shc_pkg::MinuteW-1:0] i_cfg_data
);
    import shc_pkg::*;

    logic [MinuteW-1:0] r_sunrise;
    logic [MinuteW-1:0] r_sunset;
    logic               prep_valid;
    logic               prep_stall;
    t_prep              prep_data;
    logic               div_valid;
    logic               div_stall;
    t_div               div_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sunrise <= SUNRISE_RST;
            r_sunset  <= SUNSET_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SUNRISE: r_sunrise <= i_cfg_data;
                REG_SUNSET:  r_sunset  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    shc_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_now     (i_now_minute),
        .i_sunrise (r_sunrise),
        .i_sunset  (r_sunset),
        .o_valid   (prep_valid),
        .i_stall   (prep_stall),
        .o_data    (prep_data)
    );

    shc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .o_stall (prep_stall),
        .i_data  (prep_data),
        .o_valid (div_valid),
        .i_stall (div_stall),
        .o_data  (div_data)
    );

    shc_split u_split (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (div_valid),
        .o_stall           (div_stall),
        .i_data            (div_data),
        .o_valid           (o_out_valid),
        .i_stall           (i_out_stall),
        .o_is_day          (o_is_day),
        .o_hour_number     (o_hour_number),
        .o_hours_to_next   (o_hours_to_next),
        .o_minutes_to_next (o_minutes_to_next),
        .o_config_fault    (o_config_fault)
    );

    // input back-pressure only comes from a stalled, full output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled output");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_config_fault) |->
            (!o_is_day && o_hour_number == 4'd0 && o_hours_to_next == 2'd0 &&
             o_minutes_to_next == 6'd0))
        else $error("fault result with nonzero fields");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_config_fault) |->
            (o_hour_number != 4'd0 && o_hour_number <= 4'd12 &&
             o_minutes_to_next < 6'd60 && o_hours_to_next <= 2'd1))
        else $error("result fields out of range");

endmodule

/* test/seasonal_hour_calculator_tb.sv */
// ----------------------------------------------------------------------------
// seasonal_hour_calculator testbench
// Drives minute-of-day values through the calculator under a range of
// sunrise/sunset settings, including faulty and saturating ones, and checks
// every result against a scoreboard that computes the temporal hour and the
// time left to the next hour. Sender gaps, receiver stalls and a long output
// hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import shc_pkg::*;

    typedef struct packed {
        logic       is_day;
        logic [3:0] hour_number;
        logic [1:0] hours_to_next;
        logic [5:0] minutes_to_next;
        logic       config_fault;
    } hour_result_t;

    // indexes past the register list, writes there must be ignored
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    localparam int unsigned DayMinutes  = 1440;
    localparam int unsigned LastMinute  = 1439;
    localparam int unsigned PeriodHours = 12;
    localparam int unsigned HourMinutes = 60;
    localparam int unsigned NumPhases   = 12;
    localparam int unsigned PhaseItems  = 75;

    class hour_scoreboard;
        logic [MinuteW-1:0] sunrise;
        logic [MinuteW-1:0] sunset;
        hour_result_t       expected_q[$];
        int unsigned        mismatches;
        int unsigned        results_seen;
        int unsigned        day_seen;
        int unsigned        night_seen;
        int unsigned        fault_seen;

        function new();
            sunrise      = SUNRISE_RST;
            sunset       = SUNSET_RST;
            mismatches   = 0;
            results_seen = 0;
            day_seen     = 0;
            night_seen   = 0;
            fault_seen   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [MinuteW-1:0] data);
            case (idx)
                REG_SUNRISE: sunrise = data;
                REG_SUNSET:  sunset = data;
                default: ;
            endcase
        endfunction

        function int unsigned clip_minute(int unsigned v);
            return (v > LastMinute) ? LastMinute : v;
        endfunction

        function hour_result_t temporal_hour(logic [MinuteW-1:0] now_raw);
            hour_result_t r;
            int unsigned now, sr, ss, len, elapsed, z, left, total;
            now = clip_minute(now_raw);
            sr  = clip_minute(sunrise);
            ss  = clip_minute(sunset);
            r   = '0;
            if (ss <= sr) begin
                r.config_fault = 1'b1;
                return r;
            end
            r.is_day = (now >= sr) && (now <= ss);
            if (r.is_day) begin
                len     = ss - sr;
                elapsed = now - sr;
            end else begin
                len     = DayMinutes - (ss - sr);
                // before sunrise the night started yesterday
                elapsed = (now < sr) ? now + DayMinutes - ss : now - ss;
            end
            z = (PeriodHours * elapsed) / len;
            if (z > PeriodHours - 1) z = PeriodHours - 1;
            left  = (z + 1) * len - PeriodHours * elapsed;
            total = left / PeriodHours;
            r.hour_number     = 4'(z + 1);
            r.hours_to_next   = 2'(total / HourMinutes);
            r.minutes_to_next = 6'(total % HourMinutes);
            return r;
        endfunction

        function void note_input(logic [MinuteW-1:0] now_raw);
            hour_result_t r;
            r = temporal_hour(now_raw);
            if (r.config_fault) fault_seen++;
            else if (r.is_day) day_seen++;
            else night_seen++;
            expected_q.push_back(r);
        endfunction

        function void report(string field, int unsigned e, int unsigned a);
            if (e != a) begin
                $display("%0t: %s expected %0d actual %0d", $time, field, e, a);
                mismatches++;
            end
        endfunction

        function void check_result(hour_result_t got);
            hour_result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            results_seen++;
            report("is_day", e.is_day, got.is_day);
            report("hour_number", e.hour_number, got.hour_number);
            report("hours_to_next", e.hours_to_next, got.hours_to_next);
            report("minutes_to_next", e.minutes_to_next, got.minutes_to_next);
            report("config_fault", e.config_fault, got.config_fault);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [MinuteW-1:0] i_now_minute;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_is_day;
    logic [3:0]         o_hour_number;
    logic [1:0]         o_hours_to_next;
    logic [5:0]         o_minutes_to_next;
    logic               o_config_fault;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [MinuteW-1:0] i_cfg_data;

    hour_scoreboard sb = new();
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    hold_cycles = 0;
    int unsigned    items_sent = 0;

    seasonal_hour_calculator_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_now_minute      (i_now_minute),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_is_day          (o_is_day),
        .o_hour_number     (o_hour_number),
        .o_hours_to_next   (o_hours_to_next),
        .o_minutes_to_next (o_minutes_to_next),
        .o_config_fault    (o_config_fault),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("seasonal_hour_calculator_top: mismatch");
        $finish;
    end

    // receiver: random stalls, plus a counted hold-off when requested
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall = 1'b1;
                hold_cycles--;
            end else begin
                i_out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        hour_result_t got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = {o_is_day, o_hour_number, o_hours_to_next, o_minutes_to_next,
                       o_config_fault};
                sb.check_result(got);
            end
        end
    end

    task automatic push_minute(input logic [MinuteW-1:0] v);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_now_minute = v;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(v);
        items_sent++;
        @(negedge i_clk);
        i_in_valid   = 1'b0;
        i_now_minute = MinuteW'($urandom_range(2047));
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(negedge i_clk);
        // pipeline depth plus margin
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [MinuteW-1:0] data);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_sun(input logic [MinuteW-1:0] sr, input logic [MinuteW-1:0] ss);
        write_reg(REG_SUNRISE, sr);
        write_reg(REG_SUNSET, ss);
    endtask

    // mostly legal times, some near the edges of the period, some out of range
    function automatic logic [MinuteW-1:0] pick_minute();
        int unsigned r, base;
        int          v;
        r = $urandom_range(99);
        if (r < 65) return MinuteW'($urandom_range(LastMinute));
        if (r < 88) begin
            base = $urandom_range(1) ? sb.sunrise : sb.sunset;
            v = int'(base) + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > 2047) v = 2047;
            return MinuteW'(v);
        end
        return MinuteW'($urandom_range(2047, DayMinutes));
    endfunction

    initial begin
        int unsigned sr_tab[NumPhases];
        int unsigned ss_tab[NumPhases];
        int unsigned p, k, sr_r;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_now_minute = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_SUNRISE;
        i_cfg_data   = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, boundaries and saturation
        push_minute(11'd0);
        push_minute(11'd359);
        push_minute(11'd360);
        push_minute(11'd361);
        push_minute(11'd720);
        push_minute(11'd1079);
        push_minute(11'd1080);
        push_minute(11'd1081);
        push_minute(11'd1439);
        push_minute(11'd1440);
        push_minute(11'd2047);
        set_sun(11'd0, 11'd1439);
        push_minute(11'd0);
        push_minute(11'd720);
        push_minute(11'd1439);
        set_sun(11'd0, 11'd1);
        push_minute(11'd0);
        push_minute(11'd1);
        push_minute(11'd2);
        push_minute(11'd1439);
        set_sun(11'd700, 11'd700);
        push_minute(11'd700);
        push_minute(11'd0);
        // spare indexes leave the registers alone
        write_reg(REG_SPARE_A, 11'd2047);
        write_reg(REG_SPARE_B, 11'd5);
        push_minute(11'd100);
        set_sun(11'd360, 11'd2047);
        push_minute(11'd1439);
        push_minute(11'd2047);

        sr_tab = '{360, 0, 0, 1438, 1080, 700, 2047, 100, 1439, 2000, 0, 0};
        ss_tab = '{1080, 1439, 1, 1439, 360, 700, 1500, 2047, 0, 2047, 0, 0};
        for (p = 0; p < NumPhases; p++) begin
            if (p >= NumPhases - 2) begin
                sr_r = $urandom_range(1400);
                sr_tab[p] = sr_r;
                ss_tab[p] = $urandom_range(LastMinute, sr_r + 1);
            end
            set_sun(MinuteW'(sr_tab[p]), MinuteW'(ss_tab[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (k = 0; k < PhaseItems; k++) push_minute(pick_minute());
        end

        // long output hold-off while the sender keeps offering transfers
        wait_idle();
        set_sun(11'd300, 11'd1200);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 60;
        for (k = 0; k < 30; k++) push_minute(pick_minute());

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.mismatches++;
        end
        $display("%0d time values sent over %0d sunrise/sunset settings and idle mixes",
                 items_sent, NumPhases + 6);
        $display("%0d results checked: %0d day, %0d night, %0d with bad settings",
                 sb.results_seen, sb.day_seen, sb.night_seen, sb.fault_seen);
        if (sb.mismatches == 0) begin
            $display("seasonal_hour_calculator_top: match");
        end else begin
            $display("seasonal_hour_calculator_top: mismatch");
        end
        $finish;
    end

endmodule
